/* rtl/core/cpnd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpnd_pkg
// Shared types, constants and helper functions for the cpio newc deframer.
// ----------------------------------------------------------------------------
package cpnd_pkg;

    localparam int SIZE_WIDTH  = 32;   // kept bits of decoded sizes, 16..32
    localparam int HDR_LEN     = 110;
    localparam int HEX_FIRST   = 6;    // first byte after the magic
    localparam int FSIZE_LAST  = 61;   // last digit of the file size field
    localparam int NSIZE_LAST  = 101;  // last digit of the name size field
    localparam int TRAILER_LEN = 11;   // "TRAILER!!!" plus NUL
    localparam int LEN_WIDTH   = 32;

    typedef logic [SIZE_WIDTH-1:0] size_t;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_NAME   = 3'd1,
        PH_NPAD   = 3'd2,
        PH_DATA   = 3'd3,
        PH_DPAD   = 3'd4,
        PH_DONE   = 3'd5
    } phase_t;

    typedef struct packed {
        logic [7:0]           out_byte;
        phase_t               region;
        logic                 entry_end;
        logic [LEN_WIDTH-1:0] file_length;
        logic [LEN_WIDTH-1:0] name_length;
        logic                 trailer_found;
    } result_t;

    // Non-hex characters decode as zero.
    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        logic [3:0] d;
        d = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = 4'(c - 8'h37);
        end
        return d;
    endfunction

    // Expected name byte at a given position; position ten is the NUL.
    function automatic logic [7:0] trailer_char(input logic [3:0] i);
        logic [7:0] c;
        unique case (i)
            4'd0:    c = 8'h54;  // T
            4'd1:    c = 8'h52;  // R
            4'd2:    c = 8'h41;  // A
            4'd3:    c = 8'h49;  // I
            4'd4:    c = 8'h4C;  // L
            4'd5:    c = 8'h45;  // E
            4'd6:    c = 8'h52;  // R
            4'd7:    c = 8'h21;  // !
            4'd8:    c = 8'h21;
            4'd9:    c = 8'h21;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/cpnd_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpnd_parser
// Entry state machine: tracks the part of the entry, decodes the size
// fields and matches the trailer name; labels each transferred byte.
// ----------------------------------------------------------------------------
module cpnd_parser (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_accept,
    input  wire logic [7:0]        in_byte,
    output cpnd_pkg::result_t      result
);
    import cpnd_pkg::*;

    phase_t          phase_reg, phase_next;
    size_t           cnt_reg, cnt_next;
    logic [31:0]     hex_reg, hex_next;
    size_t           fs_reg, fs_next;
    size_t           ns_reg, ns_next;
    logic            match_reg, match_next;

    logic [31:0]     hex_upd;
    size_t           fs_upd, ns_upd;
    logic            match_upd, match_end;
    logic [6:0]      hdr_off;
    logic [1:0]      npad, dpad;
    logic [4:0]      nonempty;
    size_t           part_len;
    logic            last;
    phase_t          after;

    assign hdr_off  = cnt_reg[6:0] - 7'(HEX_FIRST);
    assign npad     = 2'(2'd2 - ns_reg[1:0]);
    assign dpad     = 2'(2'd0 - fs_reg[1:0]);
    assign nonempty = {|dpad, |fs_reg, |npad, |ns_reg, 1'b1};

    always_comb begin
        hex_upd   = hex_reg;
        fs_upd    = fs_reg;
        ns_upd    = ns_reg;
        match_upd = match_reg;
        if (phase_reg == PH_HEADER) begin
            if (cnt_reg == '0) begin
                match_upd = 1'b1;
            end
            if (cnt_reg >= size_t'(HEX_FIRST)) begin
                hex_upd = ((hdr_off[2:0] == 3'd0) ? 32'd0 : {hex_reg[27:0], 4'd0})
                          | {28'd0, hex_digit(in_byte)};
            end
            if (cnt_reg == size_t'(FSIZE_LAST)) begin
                fs_upd = hex_upd[SIZE_WIDTH-1:0];
            end
            if (cnt_reg == size_t'(NSIZE_LAST)) begin
                ns_upd = hex_upd[SIZE_WIDTH-1:0];
            end
        end else if (phase_reg == PH_NAME && match_reg &&
                     cnt_reg < size_t'(TRAILER_LEN)) begin
            if (in_byte != trailer_char(cnt_reg[3:0])) begin
                match_upd = 1'b0;
            end
        end
    end

    always_comb begin
        unique case (phase_reg)
            PH_HEADER: part_len = size_t'(HDR_LEN);
            PH_NAME:   part_len = ns_reg;
            PH_NPAD:   part_len = size_t'(npad);
            PH_DATA:   part_len = fs_reg;
            PH_DPAD:   part_len = size_t'(dpad);
            default:   part_len = '0;
        endcase
    end

    assign last = (cnt_reg == size_t'(part_len - size_t'(1)));

    // next non-empty part after the current one
    always_comb begin
        after = PH_DONE;
        for (int p = 4; p >= 1; p--) begin
            if (3'(p) > phase_reg && nonempty[p]) begin
                after = phase_t'(3'(p));
            end
        end
    end

    assign match_end = match_upd &&
                       !(phase_reg == PH_HEADER && ns_reg < size_t'(TRAILER_LEN));

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        hex_next   = hex_reg;
        fs_next    = fs_reg;
        ns_next    = ns_reg;
        match_next = match_reg;
        if (in_accept && phase_reg != PH_DONE) begin
            hex_next = hex_upd;
            fs_next  = fs_upd;
            ns_next  = ns_upd;
            if (last) begin
                cnt_next   = '0;
                match_next = match_end;
                if (after == PH_DONE) begin
                    phase_next = match_end ? PH_DONE : PH_HEADER;
                end else begin
                    phase_next = after;
                end
            end else begin
                cnt_next   = size_t'(cnt_reg + size_t'(1));
                match_next = match_upd;
            end
        end
    end

    always_comb begin
        result.out_byte = in_byte;
        if (phase_reg == PH_DONE) begin
            result.region        = PH_DONE;
            result.entry_end     = 1'b0;
            result.file_length   = LEN_WIDTH'(fs_reg);
            result.name_length   = LEN_WIDTH'(ns_reg);
            result.trailer_found = 1'b1;
        end else begin
            result.region    = phase_reg;
            result.entry_end = last && (after == PH_DONE);
            if (phase_reg == PH_HEADER) begin
                result.file_length   = '0;
                result.name_length   = '0;
                result.trailer_found = 1'b0;
            end else begin
                result.file_length = LEN_WIDTH'(fs_reg);
                result.name_length = LEN_WIDTH'(ns_reg);
                if (phase_reg == PH_NAME) begin
                    result.trailer_found = match_upd &&
                                           cnt_reg >= size_t'(TRAILER_LEN - 1);
                end else begin
                    result.trailer_found = match_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            cnt_reg   <= '0;
            hex_reg   <= '0;
            fs_reg    <= '0;
            ns_reg    <= '0;
            match_reg <= 1'b1;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            hex_reg   <= hex_next;
            fs_reg    <= fs_next;
            ns_reg    <= ns_next;
            match_reg <= match_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/cpnd_out_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpnd_out_stage
// Result register with handshake; takes a new result while the held one
// is being transferred.
// ----------------------------------------------------------------------------
module cpnd_out_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire cpnd_pkg::result_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output cpnd_pkg::result_t      out_data
);
    import cpnd_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;
    logic    load;

    assign in_ready   = !valid_reg || out_ready;
    assign load       = in_valid && in_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

/* rtl/core/cpio_newc_stream_deframer_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpio_newc_stream_deframer_unit
// Labels each byte of a cpio newc archive stream with its entry region.
// ----------------------------------------------------------------------------
// One archive byte per transfer in, one labelled byte per transfer out.
// Throughput is one byte per clock unless m_tready stalls the output; the
// result is registered after the combinational parse logic. Region codes:
// 0 header, 1 name, 2 name pad, 3 data, 4 data pad, 5 past the trailer.
// tlast marks the final byte of each entry, padding included. Sizes are
// decoded from the header and reported as zero while still in the header.
// The magic is not checked.
module cpio_newc_stream_deframer_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] archive_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // [7:0] out_byte, [39:8] file_length,
                                        // [71:40] name_length
    output logic             m_tlast,   // entry_end
    output logic [3:0]       m_tuser    // [2:0] region, [3] trailer_found
);
    import cpnd_pkg::*;

    result_t parsed;
    result_t held;
    logic    s_accept;

    assign s_accept = s_tvalid && s_tready;

    cpnd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (s_accept),
        .in_byte   (s_tdata),
        .result    (parsed)
    );

    cpnd_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (parsed),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (held)
    );

    assign m_tdata = {held.name_length, held.file_length, held.out_byte};
    assign m_tlast = held.entry_end;
    assign m_tuser = {held.trailer_found, held.region};

endmodule
`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for cpio_newc_stream_deframer_unit.
// Streams whole newc entries: a table of directed entries with hand-typed
// labels on their first and last bytes, then random entries (plain, near-
// trailer names, garbage headers, sizes built from non-hex characters),
// then the trailer and a few bytes past the end. Each output transfer is
// checked against its hand-typed label if any, else a byte-level parser
// model kept inside the bench. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    import cpnd_pkg::*;

    localparam int RANDOM_ITEMS = 100;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 8;
    localparam logic [79:0] TRAILER_NAME = "TRAILER!!!";

    typedef enum logic [1:0] {
        NM_PLAIN,
        NM_TRAILER,
        NM_NO_NUL,
        NM_TYPO
    } name_kind_t;

    typedef enum logic [1:0] {
        DS_LOWER,
        DS_UPPER,
        DS_NONHEX,
        DS_MIXED
    } digit_style_t;

    typedef struct packed {
        name_kind_t   kind;
        logic [15:0]  nsz;
        logic [15:0]  fsz;
        digit_style_t style;
        logic         noise;
        logic         broken;
        logic         typed;
        phase_t       tail_region;
        logic         tail_trl;
    } entry_t;

    localparam entry_t DIRECTED_PLAN [7] = '{
        '{NM_PLAIN,   16'd0,  16'd0,   DS_LOWER,  1'b0, 1'b0, 1'b1, PH_NPAD, 1'b0},
        '{NM_PLAIN,   16'd1,  16'd1,   DS_NONHEX, 1'b0, 1'b0, 1'b1, PH_DPAD, 1'b0},
        '{NM_PLAIN,   16'd3,  16'd4,   DS_MIXED,  1'b0, 1'b0, 1'b1, PH_DATA, 1'b0},
        '{NM_TRAILER, 16'd10, 16'd0,   DS_LOWER,  1'b0, 1'b0, 1'b1, PH_NAME, 1'b0},
        '{NM_NO_NUL,  16'd11, 16'd2,   DS_UPPER,  1'b0, 1'b0, 1'b1, PH_DPAD, 1'b0},
        '{NM_TYPO,    16'd12, 16'd0,   DS_NONHEX, 1'b0, 1'b0, 1'b1, PH_NPAD, 1'b0},
        '{NM_PLAIN,   16'd6,  16'd11,  DS_UPPER,  1'b1, 1'b0, 1'b1, PH_DPAD, 1'b0}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tlast;
    logic [3:0]  m_tuser;

    // label typed in by hand for the byte currently offered
    logic        cur_typed_on = 1'b0;
    result_t     cur_typed = '0;

    result_t     expected_q [$];
    int          fail_count = 0;
    int          idle_cycles = 0;
    int          sent_bytes = 0;
    int          tx_count = 0;
    int          tx_mode = 0;
    int          rx_hold = 0;
    int          rx_count = 0;
    int          rx_mode = 0;

    // parser model state
    phase_t      st_phase = PH_HEADER;
    logic [31:0] st_idx = '0;
    logic [31:0] st_hex = '0;
    size_t       st_nsize = '0;
    size_t       st_fsize = '0;
    logic        st_match = 1'b1;
    logic        st_done = 1'b0;

    cpio_newc_stream_deframer_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #1 aclk = ~aclk;

    // {valid, value}
    function automatic logic [4:0] decode_hex(input logic [7:0] c);
        if (c inside {[8'h30:8'h39]}) return {1'b1, 4'(c - 8'h30)};
        if (c inside {[8'h61:8'h66]}) return {1'b1, 4'(c - 8'h61 + 8'd10)};
        if (c inside {[8'h41:8'h46]}) return {1'b1, 4'(c - 8'h41 + 8'd10)};
        return 5'd0;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        logic [4:0] d;
        do begin
            c = 8'($urandom_range(0, 255));
            d = decode_hex(c);
        end while (d[4]);
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input digit_style_t style);
        logic upper;
        upper = (style == DS_UPPER) || (style == DS_MIXED && $urandom_range(0, 1) == 1);
        if (v == 4'd0 && (style == DS_NONHEX || style == DS_MIXED) &&
            $urandom_range(0, 1) == 1) begin
            return non_hex_char();
        end
        if (v < 4'd10) return 8'h30 + 8'(v);
        return (upper ? 8'h41 : 8'h61) + 8'(v - 4'd10);
    endfunction

    function automatic longint seg_len(input phase_t p);
        case (p)
            PH_HEADER: return HDR_LEN;
            PH_NAME:   return longint'(st_nsize);
            PH_NPAD:   return (4 - ((HDR_LEN + longint'(st_nsize)) & 3)) & 3;
            PH_DATA:   return longint'(st_fsize);
            PH_DPAD:   return (4 - (longint'(st_fsize) & 3)) & 3;
            default:   return 0;
        endcase
    endfunction

    function automatic result_t label_byte(input logic [7:0] b);
        result_t     r;
        phase_t      ph;
        phase_t      nx;
        logic [31:0] idx;
        logic [4:0]  d;
        r = '0;
        r.out_byte = b;
        if (st_done || st_phase > PH_DPAD) begin
            r.region = PH_DONE;
            r.file_length = LEN_WIDTH'(st_fsize);
            r.name_length = LEN_WIDTH'(st_nsize);
            r.trailer_found = 1'b1;
            return r;
        end
        ph = st_phase;
        idx = st_idx;
        if (ph == PH_HEADER) begin
            if (idx == 0) st_match = 1'b1;
            if (idx >= 6) begin
                d = decode_hex(b);
                st_hex = ((idx - 6) % 8 == 0) ? {28'd0, d[3:0]} : {st_hex[27:0], d[3:0]};
                if (idx == FSIZE_LAST) st_fsize = st_hex[SIZE_WIDTH-1:0];
                if (idx == NSIZE_LAST) st_nsize = st_hex[SIZE_WIDTH-1:0];
            end
        end else if (ph == PH_NAME && st_match) begin
            if (idx < 10) begin
                if (b != TRAILER_NAME[79 - 8 * idx -: 8]) st_match = 1'b0;
            end else if (idx == 10 && b != 8'h00) begin
                st_match = 1'b0;
            end
        end

        if (ph == PH_HEADER) r.trailer_found = 1'b0;
        else if (ph == PH_NAME) r.trailer_found = st_match && idx >= 10;
        else r.trailer_found = st_match;

        r.region = ph;
        r.file_length = (ph == PH_HEADER) ? '0 : LEN_WIDTH'(st_fsize);
        r.name_length = (ph == PH_HEADER) ? '0 : LEN_WIDTH'(st_nsize);

        if (longint'(idx) + 1 < seg_len(ph)) begin
            st_idx = idx + 1;
        end else begin
            if (ph == PH_HEADER && st_nsize < 11) st_match = 1'b0;
            nx = phase_t'(ph + 1);
            while (nx <= PH_DPAD && seg_len(nx) == 0) nx = phase_t'(nx + 1);
            st_idx = '0;
            if (nx > PH_DPAD) begin
                r.entry_end = 1'b1;
                if (st_match) begin
                    st_done = 1'b1;
                    st_phase = PH_DONE;
                end else begin
                    st_phase = PH_HEADER;
                end
            end else begin
                st_phase = nx;
            end
        end
        return r;
    endfunction

    function automatic int gap_len(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 0) return 0;
        if (mode == 1) return (r < 70) ? 0 : $urandom_range(1, 3);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] seen);
        if (want !== seen) begin
            $error("%s: expected %0h, got %0h", label, want, seen);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        result_t got;
        logic    moved;
        moved = 1'b0;
        if (!aresetn) begin
            st_phase = PH_HEADER;
            st_idx = '0;
            st_hex = '0;
            st_nsize = '0;
            st_fsize = '0;
            st_match = 1'b1;
            st_done = 1'b0;
            idle_cycles = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                moved = 1'b1;
                want = label_byte(s_tdata);
                if (cur_typed_on) want = cur_typed;
                expected_q.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                moved = 1'b1;
                got.out_byte = m_tdata[7:0];
                got.file_length = m_tdata[39:8];
                got.name_length = m_tdata[71:40];
                got.region = phase_t'(m_tuser[2:0]);
                got.trailer_found = m_tuser[3];
                got.entry_end = m_tlast;
                if (expected_q.size() == 0) begin
                    $error("output transfer with nothing expected: byte %0h", got.out_byte);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
                    check_field("region", 32'(want.region), 32'(got.region));
                    check_field("entry_end", 32'(want.entry_end), 32'(got.entry_end));
                    check_field("file_length", want.file_length, got.file_length);
                    check_field("name_length", want.name_length, got.name_length);
                    check_field("trailer_found", 32'(want.trailer_found),
                                32'(got.trailer_found));
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    always @(negedge aclk) begin
        if (rx_count % 150 == 0) rx_mode = $urandom_range(0, 2);
        rx_count++;
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold--;
        end else begin
            m_tready <= 1'b1;
            rx_hold = gap_len(rx_mode);
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic typed_on, input result_t typed);
        int gap;
        if (tx_count % 48 == 0) tx_mode = $urandom_range(0, 2);
        tx_count++;
        gap = gap_len(tx_mode);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        cur_typed_on <= typed_on;
        cur_typed <= typed;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_entry(input entry_t e);
        logic [7:0]  hdr [HDR_LEN];
        logic [7:0]  q [$];
        logic [31:0] val;
        logic [4:0]  hi;
        logic [4:0]  lo;
        int          nsz;
        int          fsz;
        int          pos;
        int          p;
        result_t     head;
        result_t     tail;
        for (int i = 0; i < HEX_FIRST; i++) begin
            hdr[i] = e.noise ? 8'($urandom_range(0, 255)) : 8'("070701" >> (8 * (5 - i)));
        end
        for (int f = 0; f < 13; f++) begin
            val = (f == 6) ? 32'(e.fsz) : (f == 11) ? 32'(e.nsz) : $urandom;
            for (int k = 0; k < 8; k++) begin
                pos = HEX_FIRST + 8 * f + k;
                if (f != 6 && f != 11 && e.noise) begin
                    hdr[pos] = 8'($urandom_range(0, 255));
                end else if ((f == 6 || f == 11) && e.broken) begin
                    hdr[pos] = (k < 6) ? hex_char(4'd0, DS_NONHEX) : 8'($urandom_range(0, 255));
                end else begin
                    hdr[pos] = hex_char(val[31 - 4 * k -: 4], e.style);
                end
            end
        end
        nsz = e.nsz;
        fsz = e.fsz;
        if (e.broken) begin
            hi = decode_hex(hdr[FSIZE_LAST - 1]);
            lo = decode_hex(hdr[FSIZE_LAST]);
            fsz = {hi[3:0], lo[3:0]};
            hi = decode_hex(hdr[NSIZE_LAST - 1]);
            lo = decode_hex(hdr[NSIZE_LAST]);
            nsz = {hi[3:0], lo[3:0]};
        end
        foreach (hdr[i]) q.push_back(hdr[i]);

        for (int i = 0; i < nsz; i++) begin
            if (e.kind == NM_PLAIN || i > 10) q.push_back(8'($urandom_range(0, 255)));
            else if (i < 10) q.push_back(TRAILER_NAME[79 - 8 * i -: 8]);
            else if (e.kind == NM_NO_NUL) q.push_back(8'($urandom_range(1, 255)));
            else q.push_back(8'h00);
        end
        if (e.kind == NM_TYPO && nsz > 0) begin
            p = HDR_LEN + $urandom_range(0, (nsz < TRAILER_LEN ? nsz : TRAILER_LEN) - 1);
            q[p] = q[p] ^ 8'($urandom_range(1, 255));
        end
        repeat ((4 - ((HDR_LEN + nsz) & 3)) & 3) q.push_back(8'($urandom_range(0, 255)));
        repeat (fsz) q.push_back(8'($urandom_range(0, 255)));
        repeat ((4 - (fsz & 3)) & 3) q.push_back(8'($urandom_range(0, 255)));

        head = '0;
        head.out_byte = q[0];
        head.region = PH_HEADER;
        tail = '0;
        tail.out_byte = q[q.size() - 1];
        tail.region = e.tail_region;
        tail.entry_end = 1'b1;
        tail.file_length = LEN_WIDTH'(fsz);
        tail.name_length = LEN_WIDTH'(nsz);
        tail.trailer_found = e.tail_trl;
        foreach (q[i]) begin
            if (e.typed && i == 0) push_byte(q[i], 1'b1, head);
            else if (e.typed && i == q.size() - 1) push_byte(q[i], 1'b1, tail);
            else push_byte(q[i], 1'b0, '0);
        end
        sent_bytes += q.size();
    endtask

    function automatic entry_t random_entry();
        entry_t e;
        int     r;
        r = $urandom_range(0, 99);
        e = '0;
        e.kind = NM_PLAIN;
        e.style = digit_style_t'($urandom_range(0, 3));
        e.nsz = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 3))
                                            : 16'($urandom_range(0, 24));
        e.fsz = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(100, 260))
                                             : 16'($urandom_range(0, 40));
        if (r >= 50 && r < 70) begin
            case ($urandom_range(0, 2))
                0: begin
                    e.kind = NM_NO_NUL;
                    e.nsz = 16'($urandom_range(11, 16));
                end
                1: begin
                    e.kind = NM_TYPO;
                    e.nsz = 16'($urandom_range(1, 16));
                end
                default: begin
                    e.kind = NM_TRAILER;
                    e.nsz = 16'($urandom_range(0, 10));
                end
            endcase
        end else if (r >= 70 && r < 85) begin
            e.noise = 1'b1;
        end else if (r >= 85) begin
            e.broken = 1'b1;
            e.noise = 1'($urandom_range(0, 1));
        end
        return e;
    endfunction

    initial begin
        entry_t e;
        int     start;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED_PLAN[i]) send_entry(DIRECTED_PLAN[i]);

        // drain everything before the random part
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (expected_q.size() == 0);

        start = sent_bytes;
        while (sent_bytes - start < RANDOM_ITEMS) begin
            e = random_entry();
            send_entry(e);
        end

        e = '0;
        e.kind = NM_TRAILER;
        e.nsz = 16'($urandom_range(11, 14));
        e.fsz = 16'($urandom_range(0, 9));
        e.style = digit_style_t'($urandom_range(0, 3));
        send_entry(e);
        repeat ($urandom_range(4, 16)) push_byte(8'($urandom_range(0, 255)), 1'b0, '0);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/cpnd_pkg.sv
rtl/core/cpnd_parser.sv
rtl/core/cpnd_out_stage.sv
rtl/core/cpio_newc_stream_deframer_unit.sv
tb/tb.sv
